// ----- rtl/core/bap_pkg.sv -----
// Shared types and constants of the balance angle PID controller.
// Depends on nothing; bap_ser_mul and balance_angle_pid_top refer to it by scoped names.
package bap_pkg;

  localparam logic [1:0] KIND_ENABLE  = 2'd0;
  localparam logic [1:0] KIND_DISABLE = 2'd1;
  localparam logic [1:0] KIND_COMMAND = 2'd2;
  localparam logic [1:0] KIND_TICK    = 2'd3;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_FAULT = 2'd2;

  localparam logic [3:0] REG_SETPOINT  = 4'd0;
  localparam logic [3:0] REG_GAIN_P    = 4'd1;
  localparam logic [3:0] REG_GAIN_I    = 4'd2;
  localparam logic [3:0] REG_GAIN_D    = 4'd3;
  localparam logic [3:0] REG_FALL_THR  = 4'd4;
  localparam logic [3:0] REG_INT_LIMIT = 4'd5;
  localparam logic [3:0] REG_OUT_LIMIT = 4'd6;
  localparam logic [3:0] REG_LEAN      = 4'd7;

  localparam int MulAW = 16;
  localparam int MulBW = 18;
  localparam int MulPW = MulAW + MulBW;
  localparam int SumW  = MulPW + 2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] pitch;
    logic signed [15:0] speed_lin;
    logic signed [15:0] speed_ang;
    logic [31:0]        now_ms;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] linear_drive;
    logic signed [15:0] angular_drive;
    logic [1:0]         mode;
    logic               fell;
  } out_beat_t;

  typedef struct packed {
    logic [3:0]  reg_index;
    logic [15:0] wdata;
  } cfg_beat_t;

  function automatic logic signed [SumW-1:0] clamp_sym(logic signed [SumW-1:0] v,
                                                       logic signed [SumW-1:0] lim);
    logic signed [SumW-1:0] r;
    r = v;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    return r;
  endfunction

endpackage

// ----- rtl/core/bap_stream_if.sv -----
// Valid/ready channel interface that carries one payload beat per handshake.
// The payload type is supplied by the instantiating level from bap_pkg.
interface bap_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/core/bap_ser_mul.sv -----
// Bit-serial signed multiplier: one multiplier bit is retired per cycle.
// Depends on bap_pkg for the operand and product widths.
module bap_ser_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [bap_pkg::MulAW-1:0]     a_i,
  input  logic signed [bap_pkg::MulBW-1:0]     b_i,
  output logic                                 done_o,
  output logic signed [bap_pkg::MulPW-1:0]     p_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [4:0]                      cnt_q, cnt_d;
  logic [bap_pkg::MulBW-1:0]       b_q, b_d;
  logic signed [bap_pkg::MulPW-1:0] a_q, a_d;
  logic signed [bap_pkg::MulPW-1:0] acc_q, acc_d;
  logic                            last;

  assign last = (cnt_q == 5'(bap_pkg::MulBW - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    b_d    = b_q;
    a_d    = a_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      b_d    = b_i;
      a_d    = bap_pkg::MulPW'(a_i);
      acc_d  = '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        if (last) acc_d = acc_q - a_q;
        else acc_d = acc_q + a_q;
      end
      b_d   = b_q >> 1;
      a_d   = a_q <<< 1;
      cnt_d = cnt_q + 5'd1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q   <= b_d;
    a_q   <= a_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ----- rtl/core/balance_angle_pid_top.sv -----
// Balance angle PID controller top level with its registers and sequencer.
// Depends on bap_pkg, bap_stream_if and bap_ser_mul.
//
// Enable, disable, velocity command, a tick while not running and a tick that
// detects a fall each give their result beat in the cycle after acceptance. A
// control tick that runs the loop takes five products in turn on one
// bit-serial multiplier and gives its result beat once the output is free.
// A new beat is taken once the previous result has been delivered or is
// being taken. Configuration writes are accepted in every cycle and take
// effect at once.
module balance_angle_pid_top #(
  parameter int LEAN_MAX       = 1280,
  parameter int TURN_SCALE     = 256,
  parameter int TURN_MAX       = 256,
  parameter int CMD_TIMEOUT_MS = 500,
  parameter int FRAC_BITS      = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  bap_stream_if.sink   in_i,
  bap_stream_if.source out_o,
  bap_stream_if.sink   cfg_i
);

  localparam int SW = bap_pkg::SumW;
  localparam int PW = bap_pkg::MulPW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic signed [15:0] setpoint_q, gain_p_q, gain_i_q, gain_d_q, lean_scale_q;
  logic [14:0]        fall_thr_q, int_limit_q, out_limit_q;

  logic [1:0]         st_q, st_d;
  logic [2:0]         step_q, step_d;
  logic [1:0]         mode_q, mode_d;
  logic signed [15:0] integ_q, integ_d;
  logic signed [16:0] last_err_q, last_err_d;
  logic signed [15:0] held_lin_q, held_lin_d, held_ang_q, held_ang_d;
  logic [31:0]        cmd_time_q, cmd_time_d;
  logic signed [15:0] drv_lin_q, drv_lin_d, drv_ang_q, drv_ang_d;
  logic signed [15:0] pitch_q, pitch_d, lin_q, lin_d, ang_q, ang_d;
  logic signed [16:0] err_q, err_d;
  logic signed [PW-1:0] p_q, p_d, d_q, d_d;
  logic               out_valid_q, out_valid_d;
  bap_pkg::out_beat_t out_data_q, out_data_d;

  logic                  in_acc, out_free, mul_start, mul_done;
  logic signed [15:0]    mul_a;
  logic signed [17:0]    mul_b;
  logic signed [PW-1:0]  mul_p, mul_sh;
  logic signed [16:0]    dev;
  logic [16:0]           dev_abs;
  logic [31:0]           age;
  logic signed [SW-1:0]  lean, err_full, integ_sum, lin_sum;

  bap_ser_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (st_q == ST_IDLE) && out_free;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign mul_start = (st_q == ST_LOAD);
  assign mul_sh    = mul_p >>> FRAC_BITS;

  always_comb begin
    case (step_q)
      3'd0: begin
        mul_a = lean_scale_q;
        mul_b = 18'(lin_q);
      end
      3'd1: begin
        mul_a = gain_p_q;
        mul_b = 18'(err_q);
      end
      3'd2: begin
        mul_a = gain_i_q;
        mul_b = 18'(err_q);
      end
      3'd3: begin
        mul_a = gain_d_q;
        mul_b = 18'(err_q) - 18'(last_err_q);
      end
      default: begin
        mul_a = 16'(TURN_SCALE);
        mul_b = 18'(ang_q);
      end
    endcase
  end

  assign dev     = 17'(in_i.data.pitch) - 17'(setpoint_q);
  assign dev_abs = dev[16] ? 17'(-dev) : 17'(dev);
  assign age     = in_i.data.now_ms - cmd_time_q;

  assign lean     = bap_pkg::clamp_sym(SW'(mul_sh), SW'(LEAN_MAX));
  assign err_full = SW'(setpoint_q) + lean - SW'(pitch_q);
  assign integ_sum = bap_pkg::clamp_sym(SW'(integ_q) + SW'(mul_sh), SW'(int_limit_q));
  assign lin_sum  = bap_pkg::clamp_sym(SW'(p_q) + SW'(integ_q) + SW'(d_q),
                                       SW'(out_limit_q));

  always_comb begin
    st_d        = st_q;
    step_d      = step_q;
    mode_d      = mode_q;
    integ_d     = integ_q;
    last_err_d  = last_err_q;
    held_lin_d  = held_lin_q;
    held_ang_d  = held_ang_q;
    cmd_time_d  = cmd_time_q;
    drv_lin_d   = drv_lin_q;
    drv_ang_d   = drv_ang_q;
    pitch_d     = pitch_q;
    lin_d       = lin_q;
    ang_d       = ang_q;
    err_d       = err_q;
    p_d         = p_q;
    d_d         = d_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;

    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_data_d.fell = 1'b0;
          case (in_i.data.kind)
            bap_pkg::KIND_ENABLE: begin
              integ_d    = '0;
              last_err_d = '0;
              mode_d     = bap_pkg::MODE_ON;
            end
            bap_pkg::KIND_DISABLE: begin
              mode_d    = bap_pkg::MODE_OFF;
              drv_lin_d = '0;
              drv_ang_d = '0;
            end
            bap_pkg::KIND_COMMAND: begin
              held_lin_d = in_i.data.speed_lin;
              held_ang_d = in_i.data.speed_ang;
              cmd_time_d = in_i.data.now_ms;
            end
            default: begin
              if (mode_q == bap_pkg::MODE_ON) begin
                if (dev_abs > 17'(fall_thr_q)) begin
                  mode_d          = bap_pkg::MODE_FAULT;
                  drv_lin_d       = '0;
                  drv_ang_d       = '0;
                  out_data_d.fell = 1'b1;
                end else begin
                  pitch_d = in_i.data.pitch;
                  if (age < 32'(CMD_TIMEOUT_MS)) begin
                    lin_d = held_lin_q;
                    ang_d = held_ang_q;
                  end else begin
                    lin_d = '0;
                    ang_d = '0;
                  end
                  step_d = '0;
                  st_d   = ST_LOAD;
                end
              end
            end
          endcase
          if (st_d == ST_IDLE) begin
            out_valid_d              = 1'b1;
            out_data_d.linear_drive  = drv_lin_d;
            out_data_d.angular_drive = drv_ang_d;
            out_data_d.mode          = mode_d;
          end
        end
      end
      ST_LOAD: begin
        st_d = ST_RUN;
      end
      ST_RUN: begin
        if (mul_done) begin
          st_d   = ST_LOAD;
          step_d = step_q + 3'd1;
          case (step_q)
            3'd0: begin
              if (err_full > SW'(65535)) err_d = 17'sd65535;
              else if (err_full < -SW'(65536)) err_d = -17'sd65536;
              else err_d = err_full[16:0];
            end
            3'd1: p_d = mul_sh;
            3'd2: integ_d = integ_sum[15:0];
            3'd3: begin
              d_d        = mul_sh;
              last_err_d = err_q;
            end
            default: begin
              drv_ang_d = 16'(bap_pkg::clamp_sym(SW'(mul_sh), SW'(TURN_MAX)));
              drv_lin_d = lin_sum[15:0];
              st_d      = ST_DONE;
            end
          endcase
        end
      end
      default: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_data_d.linear_drive  = drv_lin_q;
          out_data_d.angular_drive = drv_ang_q;
          out_data_d.mode          = mode_q;
          out_data_d.fell          = 1'b0;
          st_d                     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      step_q       <= '0;
      mode_q       <= bap_pkg::MODE_OFF;
      integ_q      <= '0;
      last_err_q   <= '0;
      held_lin_q   <= '0;
      held_ang_q   <= '0;
      cmd_time_q   <= '0;
      drv_lin_q    <= '0;
      drv_ang_q    <= '0;
      out_valid_q  <= 1'b0;
      setpoint_q   <= '0;
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      fall_thr_q   <= 15'd7680;
      int_limit_q  <= 15'd256;
      out_limit_q  <= 15'd256;
      lean_scale_q <= '0;
    end else begin
      st_q        <= st_d;
      step_q      <= step_d;
      mode_q      <= mode_d;
      integ_q     <= integ_d;
      last_err_q  <= last_err_d;
      held_lin_q  <= held_lin_d;
      held_ang_q  <= held_ang_d;
      cmd_time_q  <= cmd_time_d;
      drv_lin_q   <= drv_lin_d;
      drv_ang_q   <= drv_ang_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        case (cfg_i.data.reg_index)
          bap_pkg::REG_SETPOINT:  setpoint_q   <= cfg_i.data.wdata;
          bap_pkg::REG_GAIN_P:    gain_p_q     <= cfg_i.data.wdata;
          bap_pkg::REG_GAIN_I:    gain_i_q     <= cfg_i.data.wdata;
          bap_pkg::REG_GAIN_D:    gain_d_q     <= cfg_i.data.wdata;
          bap_pkg::REG_FALL_THR:  fall_thr_q   <= cfg_i.data.wdata[14:0];
          bap_pkg::REG_INT_LIMIT: int_limit_q  <= cfg_i.data.wdata[14:0];
          bap_pkg::REG_OUT_LIMIT: out_limit_q  <= cfg_i.data.wdata[14:0];
          bap_pkg::REG_LEAN:      lean_scale_q <= cfg_i.data.wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pitch_q    <= pitch_d;
    lin_q      <= lin_d;
    ang_q      <= ang_d;
    err_q      <= err_d;
    p_q        <= p_d;
    d_q        <= d_d;
    out_data_q <= out_data_d;
  end

endmodule

// ----- tb/tb_pkg_placeholder.sv -----
// Testbench interface instances come from the block's own bap_stream_if.
// This file holds the testbench-side register mirror type used by the checker.
// Depends on bap_pkg.
package tb_bap_pkg;
  import bap_pkg::*;

  typedef struct {
    logic signed [15:0] setpoint;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic [14:0]        fall_thr;
    logic [14:0]        int_limit;
    logic [14:0]        out_limit;
    logic signed [15:0] lean;
  } regs_t;
endpackage

// ----- tb/tb_checker.sv -----
// Watches the input, output and register channels of the balance angle PID,
// predicts each result beat and compares it field by field.
// Depends on bap_pkg, tb_bap_pkg and bap_stream_if.
module tb_checker (
  input  logic clk_i,
  input  logic rst_ni,
  bap_stream_if in_i,
  bap_stream_if out_i,
  bap_stream_if cfg_i,
  output int    fail_count_o,
  output int    pending_o,
  output int    ticks_run_o,
  output int    falls_o
);
  import bap_pkg::*;
  import tb_bap_pkg::*;

  localparam longint LeanMax = 1280;
  localparam longint TurnScale = 256;
  localparam longint TurnMax = 256;
  localparam int unsigned CmdTimeout = 500;

  regs_t regs;
  logic [1:0] run_mode;
  longint integ, last_err, held_lin, held_ang, drv_lin, drv_ang;
  logic [31:0] cmd_time;
  out_beat_t expected_q[$];

  assign pending_o = expected_q.size();

  function automatic longint fshift(longint v);
    return v >>> 8;
  endfunction

  function automatic longint clampl(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  task automatic write_reg(cfg_beat_t c);
    case (c.reg_index)
      REG_SETPOINT:  regs.setpoint = c.wdata;
      REG_GAIN_P:    regs.gain_p = c.wdata;
      REG_GAIN_I:    regs.gain_i = c.wdata;
      REG_GAIN_D:    regs.gain_d = c.wdata;
      REG_FALL_THR:  regs.fall_thr = c.wdata[14:0];
      REG_INT_LIMIT: regs.int_limit = c.wdata[14:0];
      REG_OUT_LIMIT: regs.out_limit = c.wdata[14:0];
      REG_LEAN:      regs.lean = c.wdata;
      default: ;
    endcase
  endtask

  task automatic predict_drive(in_beat_t b);
    out_beat_t r;
    longint dev, lin, ang, lean, err, p, d;
    logic fell;
    fell = 1'b0;
    case (b.kind)
      KIND_ENABLE: begin
        integ = 0;
        last_err = 0;
        run_mode = MODE_ON;
      end
      KIND_DISABLE: begin
        run_mode = MODE_OFF;
        drv_lin = 0;
        drv_ang = 0;
      end
      KIND_COMMAND: begin
        held_lin = longint'(b.speed_lin);
        held_ang = longint'(b.speed_ang);
        cmd_time = b.now_ms;
      end
      default: begin
        if (run_mode == MODE_ON) begin
          dev = longint'(b.pitch) - longint'(regs.setpoint);
          if (dev < 0) dev = -dev;
          if (dev > longint'(regs.fall_thr)) begin
            fell = 1'b1;
            falls_o++;
            run_mode = MODE_FAULT;
            drv_lin = 0;
            drv_ang = 0;
          end else begin
            ticks_run_o++;
            lin = 0;
            ang = 0;
            if (32'(b.now_ms - cmd_time) < CmdTimeout) begin
              lin = held_lin;
              ang = held_ang;
            end
            lean = clampl(fshift(lin * longint'(regs.lean)), LeanMax);
            err = longint'(regs.setpoint) + lean - longint'(b.pitch);
            if (err > 65535) err = 65535;
            if (err < -65536) err = -65536;
            p = fshift(longint'(regs.gain_p) * err);
            integ = clampl(integ + fshift(longint'(regs.gain_i) * err),
                           longint'(regs.int_limit));
            d = fshift(longint'(regs.gain_d) * (err - last_err));
            last_err = err;
            drv_lin = clampl(p + integ + d, longint'(regs.out_limit));
            drv_ang = clampl(fshift(ang * TurnScale), TurnMax);
          end
        end
      end
    endcase
    r.linear_drive = drv_lin[15:0];
    r.angular_drive = drv_ang[15:0];
    r.mode = run_mode;
    r.fell = fell;
    expected_q.push_back(r);
  endtask

  task automatic compare_drive(out_beat_t got);
    out_beat_t exp_r;
    if (expected_q.size() == 0) begin
      $error("result beat with no expectation waiting");
      fail_count_o++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.linear_drive !== exp_r.linear_drive) begin
      $error("linear_drive expected %0d actual %0d", exp_r.linear_drive, got.linear_drive);
      fail_count_o++;
    end
    if (got.angular_drive !== exp_r.angular_drive) begin
      $error("angular_drive expected %0d actual %0d", exp_r.angular_drive,
             got.angular_drive);
      fail_count_o++;
    end
    if (got.mode !== exp_r.mode) begin
      $error("mode expected %0d actual %0d", exp_r.mode, got.mode);
      fail_count_o++;
    end
    if (got.fell !== exp_r.fell) begin
      $error("fell expected %0d actual %0d", exp_r.fell, got.fell);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    ticks_run_o = 0;
    falls_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.setpoint = 0;
      regs.gain_p = 0;
      regs.gain_i = 0;
      regs.gain_d = 0;
      regs.fall_thr = 15'd7680;
      regs.int_limit = 15'd256;
      regs.out_limit = 15'd256;
      regs.lean = 0;
      run_mode = MODE_OFF;
      integ = 0;
      last_err = 0;
      held_lin = 0;
      held_ang = 0;
      cmd_time = 0;
      drv_lin = 0;
      drv_ang = 0;
      expected_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) compare_drive(out_i.data);
      if (cfg_i.valid && cfg_i.ready) write_reg(cfg_i.data);
      if (in_i.valid && in_i.ready) predict_drive(in_i.data);
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top of the balance angle PID: clock, reset, stimulus and verdict.
// Depends on bap_pkg, bap_stream_if, tb_checker and the block.
module tb_top;
  import bap_pkg::*;

  localparam logic [3:0] RegSpare = 4'd12;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   ticks_run;
  int   falls;
  int   hold_cycles;
  bit   stimulus_done;
  logic [31:0] now_ms;

  bap_stream_if #(.payload_t(in_beat_t))  in_ch ();
  bap_stream_if #(.payload_t(out_beat_t)) out_ch ();
  bap_stream_if #(.payload_t(cfg_beat_t)) cfg_ch ();

  balance_angle_pid_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  tb_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .cfg_i       (cfg_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .ticks_run_o (ticks_run),
    .falls_o     (falls)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 60));
  endfunction

  // The write stays offered until the caller drops valid after the last beat.
  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{reg_index: idx, wdata: val};
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
  endtask

  // Valid is dropped by the next item when a gap follows, or by drain().
  task automatic send_item(logic [1:0] kind, logic [15:0] pitch, logic [15:0] lin,
                           logic [15:0] ang, logic [31:0] stamp);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{kind: kind, pitch: pitch, speed_lin: lin, speed_ang: ang,
                    now_ms: stamp};
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic program_regs(int phase);
    logic [15:0] v[8];
    case (phase)
      0: v = '{16'h0000, 16'h0200, 16'h0040, 16'h0080, 16'h1E00, 16'h0400, 16'h0800,
               16'h0100};
      1: v = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
               16'h7FFF};
      2: v = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000,
               16'h8000};
      default: begin
        v[0] = 16'($urandom_range(0, 2047) - 1024);
        v[1] = 16'($urandom());
        v[2] = 16'($urandom_range(0, 511) - 256);
        v[3] = 16'($urandom_range(0, 2047) - 1024);
        v[4] = 16'($urandom_range(256, 12000));
        v[5] = 16'($urandom_range(0, 4096));
        v[6] = 16'($urandom_range(0, 8192));
        v[7] = 16'($urandom());
      end
    endcase
    write_reg(REG_SETPOINT, v[0]);
    write_reg(REG_GAIN_P, v[1]);
    write_reg(REG_GAIN_I, v[2]);
    write_reg(REG_GAIN_D, v[3]);
    write_reg(REG_FALL_THR, v[4]);
    write_reg(REG_INT_LIMIT, v[5]);
    write_reg(REG_OUT_LIMIT, v[6]);
    write_reg(REG_LEAN, v[7]);
    write_reg(RegSpare, 16'($urandom()));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_item(int phase);
    int r;
    logic [15:0] pitch;
    r = $urandom_range(0, 99);
    now_ms += $urandom_range(0, 99) < 90 ? $urandom_range(0, 40) : $urandom_range(400, 900);
    if ($urandom_range(0, 199) == 0) now_ms = $urandom();
    pitch = (phase == 1 || $urandom_range(0, 9) == 0) ? 16'($urandom()) :
            16'($urandom_range(0, 4095) - 2048);
    if (r < 5) send_item(KIND_ENABLE, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                         now_ms);
    else if (r < 8) send_item(KIND_DISABLE, 16'($urandom()), 16'($urandom()),
                              16'($urandom()), now_ms);
    else if (r < 25) send_item(KIND_COMMAND, 16'($urandom()), 16'($urandom()),
                               16'($urandom()), now_ms);
    else send_item(KIND_TICK, pitch, 16'($urandom()), 16'($urandom()), now_ms);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    stimulus_done = 1'b0;
    now_ms = 32'd1000;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: ticks while off and a fall at reset values, then loop extremes.
    send_item(KIND_TICK, 16'h0100, 16'd0, 16'd0, now_ms);
    send_item(KIND_ENABLE, 16'd0, 16'd0, 16'd0, now_ms);
    send_item(KIND_TICK, 16'h0000, 16'd0, 16'd0, now_ms);
    send_item(KIND_TICK, 16'h7FFF, 16'd0, 16'd0, now_ms);
    send_item(KIND_TICK, 16'h0100, 16'd0, 16'd0, now_ms);
    send_item(KIND_ENABLE, 16'd0, 16'd0, 16'd0, now_ms);
    drain();
    program_regs(0);
    send_item(KIND_COMMAND, 16'd0, 16'h7FFF, 16'h8000, now_ms);
    send_item(KIND_TICK, 16'h1E00, 16'd0, 16'd0, now_ms + 499);
    send_item(KIND_TICK, 16'hE200, 16'd0, 16'd0, now_ms + 500);
    send_item(KIND_COMMAND, 16'd0, 16'h8000, 16'h7FFF, 32'hFFFF_FFF0);
    send_item(KIND_TICK, 16'hE200, 16'd0, 16'd0, 32'h0000_0010);
    send_item(KIND_TICK, 16'hE1FF, 16'd0, 16'd0, 32'h0000_0020);
    send_item(KIND_ENABLE, 16'd0, 16'd0, 16'd0, 32'd0);
    send_item(KIND_DISABLE, 16'd0, 16'd0, 16'd0, 32'd0);
    drain();
    program_regs(1);
    send_item(KIND_ENABLE, 16'd0, 16'd0, 16'd0, 32'd0);
    send_item(KIND_COMMAND, 16'd0, 16'h7FFF, 16'h7FFF, 32'd0);
    send_item(KIND_TICK, 16'h8000, 16'd0, 16'd0, 32'd1);
    send_item(KIND_TICK, 16'h8000, 16'd0, 16'd0, 32'd2);
    drain();
    program_regs(2);
    send_item(KIND_ENABLE, 16'd0, 16'd0, 16'd0, 32'd0);
    send_item(KIND_COMMAND, 16'd0, 16'h8000, 16'h8000, 32'd0);
    send_item(KIND_TICK, 16'h8000, 16'd0, 16'd0, 32'd1);
    send_item(KIND_TICK, 16'h7FFF, 16'd0, 16'd0, 32'd2);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      program_regs(phase < 3 ? phase : 3);
      send_item(KIND_ENABLE, 16'd0, 16'd0, 16'd0, now_ms);
      for (int n = 0; n < 205; n++) begin
        random_item(phase);
        if ($urandom_range(0, 29) == 0) send_item(KIND_ENABLE, 16'd0, 16'd0, 16'd0, now_ms);
      end
      drain();
    end
    stimulus_done = 1'b1;
  end

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!stimulus_done && $urandom_range(0, 299) == 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < 400) begin
          @(negedge clk_i);
          hold_cycles++;
        end
      end else if ($urandom_range(0, 99) < 60) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        repeat (gap_len()) @(negedge clk_i);
      end
    end
  end

  initial begin
    wait (stimulus_done);
    $display("Covered %0d loop ticks and %0d falls over several register settings.",
             ticks_run, falls);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// ----- balance_angle_pid_top.f -----
rtl/core/bap_pkg.sv
rtl/core/bap_stream_if.sv
rtl/core/bap_ser_mul.sv
rtl/core/balance_angle_pid_top.sv
tb/tb_pkg_placeholder.sv
tb/tb_checker.sv
tb/tb_top.sv
